[rtl/mfq_pkg.sv]
package mfq_pkg;

    localparam int QW   = 16;
    localparam int TIMW = 32;

    typedef enum logic [0:0] {
        MODE_ADMIT    = 1'b0,
        MODE_DISPATCH = 1'b1
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_REJECT = 2'd1,
        ST_EMPTY  = 2'd2
    } t_status;

    localparam logic [1:0] LVL_0 = 2'd0;
    localparam logic [1:0] LVL_1 = 2'd1;
    localparam logic [1:0] LVL_2 = 2'd2;

    localparam logic [1:0] CFG_Q0 = 2'd0;
    localparam logic [1:0] CFG_Q1 = 2'd1;
    localparam logic [1:0] CFG_Q2 = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADMIT,
        S_POP,
        S_TREAD,
        S_EXEC,
        S_TURN,
        S_DONE
    } t_state;

    typedef struct packed {
        logic        mode;
        logic [6:0]  task_id;
        logic [31:0] arrival_time;
        logic [15:0] burst_time;
        logic        io_event;
        logic [1:0]  low_queue_pick;
    } t_in_item;

    typedef struct packed {
        logic [6:0]  served_task;
        logic [15:0] ran_time;
        logic        finished;
        logic [31:0] finish_time;
        logic [31:0] turnaround;
        logic [31:0] waiting;
        logic [1:0]  level;
        logic [1:0]  status;
    } t_out_item;

    // One row of the task table
    typedef struct packed {
        logic [31:0] arrival;
        logic [15:0] burst;
        logic [15:0] remaining;
        logic [1:0]  level;
    } t_task_rec;

    // Queue commands from the sequencer
    typedef struct packed {
        logic       push;
        logic [1:0] push_lv;
        logic       pop;
        logic [1:0] pop_lv;
    } t_fifo_cmd;

endpackage

[rtl/mfq_fifo.sv]
module mfq_fifo #(
    parameter int MAX_TASKS = 128,
    localparam int TW = $clog2(MAX_TASKS)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mfq_pkg::t_fifo_cmd i_cmd,
    input  logic [TW-1:0]     i_push_task,
    output logic [TW-1:0]     o_pop_task,
    output logic [2:0]        o_nonempty
);
    import mfq_pkg::*;

    localparam int CW = $clog2(MAX_TASKS + 1);

    logic [TW-1:0] r_slot [3][MAX_TASKS];
    logic [TW-1:0] r_head [3];
    logic [TW-1:0] r_tail [3];
    logic [CW-1:0] r_count [3];
    logic [2:0]    push_hit;
    logic [2:0]    pop_hit;

    // Decode per-level push and pop
    always_comb begin
        for (int l = 0; l < 3; l++) begin
            push_hit[l] = i_cmd.push && (i_cmd.push_lv == 2'(l))
                          && (r_count[l] < CW'(MAX_TASKS));
            pop_hit[l]  = i_cmd.pop && (i_cmd.pop_lv == 2'(l));
            o_nonempty[l] = (r_count[l] != '0);
        end
    end

    // Slot memory: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (|push_hit) begin
            r_slot[i_cmd.push_lv][r_tail[i_cmd.push_lv]] <= i_push_task;
        end
        if (i_cmd.pop) begin
            o_pop_task <= r_slot[i_cmd.pop_lv][r_head[i_cmd.pop_lv]];
        end
    end

    // Advance pointers and counts
    always_ff @(posedge i_clk) begin
        for (int l = 0; l < 3; l++) begin
            if (!i_rst_n) begin
                r_head[l]  <= '0;
                r_tail[l]  <= '0;
                r_count[l] <= '0;
            end else begin
                if (push_hit[l]) begin
                    r_tail[l] <= (r_tail[l] == TW'(MAX_TASKS - 1)) ? '0 : r_tail[l] + 1'b1;
                end
                if (pop_hit[l]) begin
                    r_head[l] <= (r_head[l] == TW'(MAX_TASKS - 1)) ? '0 : r_head[l] + 1'b1;
                end
                if (push_hit[l] && !pop_hit[l]) begin
                    r_count[l] <= r_count[l] + 1'b1;
                end else if (pop_hit[l] && !push_hit[l]) begin
                    r_count[l] <= r_count[l] - 1'b1;
                end
            end
        end
    end

endmodule

[rtl/multilevel_feedback_queue_scheduler.sv]
// Three-level feedback queue scheduler.
// Input channel (i_in_valid / o_in_stall, i_in_item): an admit item records a task
// and queues it at level 0 unless rejected; a dispatch item runs the head of the highest
// non-empty level for one slice and requeues or retires it, or reports all levels empty.
// Output channel (o_out_valid / i_out_stall, o_out_item): exactly one result
// per item, in order, held in an output register.
// Configuration: i_cfg_we writes quantum register i_cfg_idx (0..2) with the
// low 16 bits of i_cfg_data; write only while the block is idle.
// Timing: one item is in work at a time. An admit result is loaded from the
// admit step; a dispatch result passes the queue-slot read, the task-table
// read, the slice arithmetic, the turnaround subtract and the result and
// write-back step, each a state of its own, and is loaded from the last.
// The next item is accepted as soon as the previous result is loaded, even
// while that result still waits in the output register. When the receiver
// stalls with a result pending, the next item stops in its last step until
// the register frees.
// Reset clears the clock, queue pointers and active flags; the task table
// and queue slots need no clearing, so the block is ready right after reset.
module multilevel_feedback_queue_scheduler #(
    parameter int MAX_TASKS = 128
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  mfq_pkg::t_in_item   i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output mfq_pkg::t_out_item  o_out_item,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_idx,
    input  logic [15:0]         i_cfg_data
);
    import mfq_pkg::*;

    localparam int TW = $clog2(MAX_TASKS);

    t_state        r_state, n_state;
    t_in_item      r_item;
    logic [15:0]   r_q0, r_q1, r_q2, r_q;
    logic [31:0]   r_now;
    logic [MAX_TASKS-1:0] r_active;
    logic [TW-1:0] r_t;
    logic [1:0]    r_lv;
    logic          r_empty;
    t_task_rec     r_rec;
    logic [15:0]   r_run, r_rem;
    logic [31:0]   r_turn;
    t_task_rec     r_task_mem [MAX_TASKS];
    t_task_rec     r_task_rd;

    t_fifo_cmd     fifo_cmd;
    logic [TW-1:0] fifo_push_task, fifo_pop_task;
    logic [2:0]    nonempty;

    logic          out_free, out_load, accept;
    t_out_item     out_n;
    logic          task_we;
    logic [TW-1:0] task_wa, task_ra;
    t_task_rec     task_wd;
    logic [TW-1:0] tid_idx;
    logic          reject, fin;
    logic [1:0]    new_lv;
    logic [15:0]   run_c;
    logic [32:0]   sum_c;
    logic [1:0]    cur_c;
    t_task_rec     rec_c;

    mfq_fifo #(.MAX_TASKS(MAX_TASKS)) u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (fifo_cmd),
        .i_push_task (fifo_push_task),
        .o_pop_task  (fifo_pop_task),
        .o_nonempty  (nonempty)
    );

    assign out_free   = !o_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign accept     = i_in_valid && !o_in_stall;
    assign tid_idx    = TW'(r_item.task_id);
    assign reject     = (32'(r_item.task_id) >= 32'(MAX_TASKS)) || r_active[tid_idx];
    assign fin        = (r_rem == '0);

    // Slice arithmetic for the execute step
    assign run_c = (r_q > r_task_rd.remaining) ? r_task_rd.remaining : r_q;
    assign sum_c = {1'b0, r_now} + 33'(run_c);
    assign cur_c = (r_task_rd.level > LVL_2) ? LVL_2 : r_task_rd.level;

    // Clamp the stored level of the row just read
    always_comb begin
        rec_c       = r_task_rd;
        rec_c.level = cur_c;
    end

    // Pick the level for a task that keeps running
    always_comb begin
        new_lv = r_rec.level;
        if (r_item.io_event) begin
            if (r_rec.level != LVL_0) new_lv = r_rec.level - 1'b1;
        end else begin
            case (r_rec.level)
                LVL_0:   new_lv = (r_run == r_q0) ? LVL_1 : LVL_0;
                LVL_1:   new_lv = (r_run == r_q1) ? LVL_2 : LVL_1;
                default: begin
                    if (r_item.low_queue_pick == LVL_0) new_lv = LVL_0;
                    else if (r_item.low_queue_pick == LVL_1) new_lv = LVL_1;
                    else new_lv = LVL_2;
                end
            endcase
        end
    end

    // Sequencer: next state, queue commands, table write, result
    always_comb begin
        n_state        = r_state;
        fifo_cmd       = '0;
        fifo_push_task = r_t;
        task_we        = 1'b0;
        task_wa        = r_t;
        task_wd        = r_rec;
        task_ra        = fifo_pop_task;
        out_load       = 1'b0;
        out_n          = '0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = (i_in_item.mode == MODE_ADMIT) ? S_ADMIT : S_POP;
                end
            end
            S_ADMIT: begin
                out_n.served_task = r_item.task_id;
                out_n.level       = LVL_0;
                out_n.status      = reject ? ST_REJECT : ST_OK;
                if (out_free) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                    if (!reject) begin
                        task_we          = 1'b1;
                        task_wa          = tid_idx;
                        task_wd.arrival  = r_item.arrival_time;
                        task_wd.burst    = r_item.burst_time;
                        task_wd.remaining = r_item.burst_time;
                        task_wd.level    = LVL_0;
                        fifo_cmd.push    = 1'b1;
                        fifo_cmd.push_lv = LVL_0;
                        fifo_push_task   = tid_idx;
                    end
                end
            end
            S_POP: begin
                fifo_cmd.pop    = |nonempty;
                fifo_cmd.pop_lv = nonempty[0] ? LVL_0 : (nonempty[1] ? LVL_1 : LVL_2);
                n_state         = (|nonempty) ? S_TREAD : S_DONE;
            end
            S_TREAD: begin
                n_state = S_EXEC;
            end
            S_EXEC: begin
                n_state = S_TURN;
            end
            S_TURN: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (r_empty) begin
                    out_n.status = ST_EMPTY;
                end else begin
                    out_n.served_task = 7'(r_t);
                    out_n.ran_time    = r_run;
                    out_n.finished    = fin;
                    out_n.status      = ST_OK;
                    if (fin) begin
                        out_n.finish_time = r_now;
                        out_n.turnaround  = r_turn;
                        out_n.waiting     = (r_turn >= 32'(r_rec.burst)) ?
                                            r_turn - 32'(r_rec.burst) : '0;
                        out_n.level       = r_rec.level;
                    end else begin
                        out_n.level       = new_lv;
                    end
                end
                if (out_free) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                    if (!r_empty) begin
                        task_we           = 1'b1;
                        task_wd.remaining = r_rem;
                        task_wd.level     = fin ? r_rec.level : new_lv;
                        fifo_cmd.push     = !fin;
                        fifo_cmd.push_lv  = new_lv;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    // Task table: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (task_we) r_task_mem[task_wa] <= task_wd;
        r_task_rd <= r_task_mem[task_ra];
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q0 <= 16'd15;
            r_q1 <= 16'd60;
            r_q2 <= 16'd150;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_Q0:  r_q0 <= i_cfg_data;
                CFG_Q1:  r_q1 <= i_cfg_data;
                CFG_Q2:  r_q2 <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Control state: clock, active flags, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_now       <= '0;
            r_active    <= '0;
            o_out_valid <= 1'b0;
        end else begin
            if (out_load) o_out_valid <= 1'b1;
            else if (!i_out_stall) o_out_valid <= 1'b0;
            if (r_state == S_ADMIT && out_free && !reject) begin
                r_active[tid_idx] <= 1'b1;
                if (!(|nonempty) && r_item.arrival_time > r_now) r_now <= r_item.arrival_time;
            end
            if (r_state == S_EXEC) begin
                r_now <= sum_c[32] ? '1 : sum_c[31:0];
            end
            if (r_state == S_DONE && out_free && !r_empty && fin) begin
                r_active[r_t] <= 1'b0;
            end
        end
    end

    // Payload registers along the dispatch steps
    always_ff @(posedge i_clk) begin
        if (accept) r_item <= i_in_item;
        if (out_load) o_out_item <= out_n;
        case (r_state)
            S_POP: begin
                r_empty <= !(|nonempty);
                r_lv    <= fifo_cmd.pop_lv;
                r_q     <= nonempty[0] ? r_q0 : (nonempty[1] ? r_q1 : r_q2);
            end
            S_TREAD: r_t <= fifo_pop_task;
            S_EXEC: begin
                r_run <= run_c;
                r_rem <= r_task_rd.remaining - run_c;
                r_rec <= rec_c;
            end
            S_TURN: r_turn <= (r_now >= r_rec.arrival) ? r_now - r_rec.arrival : '0;
            default: ;
        endcase
    end

    // Clock never runs backwards
    a_now_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> r_now >= $past(r_now))
        else $error("scheduler clock decreased");

    // A popped task is read from the table in the next step
    a_pop_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_POP && |nonempty) |=> r_state == S_TREAD)
        else $error("pop not followed by table read");

    // Results never carry an illegal level
    a_out_lvl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_item.level != 2'd3)
        else $error("illegal level in result");

    // Level 0 is popped whenever it is non-empty
    a_pop_lv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_POP && nonempty[0]) |=> r_lv == LVL_0)
        else $error("dispatch skipped level 0");

endmodule
